// ===== hdl/snfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// snfcs_pkg
// Shared types and constants of the SPI NOR flash command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package snfcs_pkg;

    // Flash geometry
    localparam int ADDRESS_BITS = 24;
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;

    localparam int ADDR_BYTES = (ADDRESS_BITS + 7) / 8;
    localparam int PAGE_LOG   = $clog2(PAGE_BYTES);
    localparam int SECTOR_LOG = $clog2(SECTOR_BYTES);

    // Field widths
    localparam int CMD_W      = 3;
    localparam int IN_ADDR_W  = 32;
    localparam int LEN_W      = 25;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int TIMEOUT_W  = 16;
    localparam int IDX_W      = 3;
    localparam int END_W      = ADDRESS_BITS + 1;
    localparam int SUM_W      = IN_ADDR_W + 2;

    localparam logic [SUM_W-1:0] FLASH_SIZE = SUM_W'(1) << ADDRESS_BITS;

    // Stream widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(5000);

    // Flash opcodes
    localparam logic [BYTE_W-1:0] OP_WREN  = 8'h06;
    localparam logic [BYTE_W-1:0] OP_RDSR  = 8'h05;
    localparam logic [BYTE_W-1:0] OP_PROG  = 8'h02;
    localparam logic [BYTE_W-1:0] OP_READ  = 8'h03;
    localparam logic [BYTE_W-1:0] OP_RDID  = 8'h9F;
    localparam logic [BYTE_W-1:0] OP_SE    = 8'h20;
    localparam logic [BYTE_W-1:0] DUMMY    = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ_ID      = 3'd0,
        CMD_READ         = 3'd1,
        CMD_PROGRAM      = 3'd2,
        CMD_SECTOR_ERASE = 3'd3,
        CMD_ERASE_RANGE  = 3'd4,
        CMD_DATA_BYTE    = 3'd5,
        CMD_FLASH_BYTE   = 3'd6,
        CMD_TICK         = 3'd7
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef struct packed {
        t_command               command;
        logic [IN_ADDR_W-1:0]   address;
        logic [LEN_W-1:0]       length;
        logic [BYTE_W-1:0]      data_byte;
        logic [BYTE_W-1:0]      flash_byte;
    } t_item;

    typedef struct packed {
        logic                   send_valid;
        logic [BYTE_W-1:0]      send_byte;
        logic                   select_start;
        logic                   select_end;
        logic                   reply_valid;
        logic [BYTE_W-1:0]      reply_byte;
        logic                   want_data;
        logic                   done_res;
        t_status                status;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/snfcs_core.sv =====
// ----------------------------------------------------------------------------
// snfcs_core
// Sequencer state and next-state logic; one item per step.
// ----------------------------------------------------------------------------
`default_nettype none

module snfcs_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_step,
    input  wire snfcs_pkg::t_item                    i_item,
    input  wire logic [snfcs_pkg::TIMEOUT_W-1:0]     i_timeout_ms,
    output logic                                     o_have_res,
    output snfcs_pkg::t_result                       o_res
);
    import snfcs_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ID_CMD, PH_ID_DATA, PH_ADDR, PH_READ_DATA, PH_WE_CMD,
        PH_WE_POLL_CMD, PH_WE_POLL_DAT, PH_DATA_WAIT, PH_DATA_SENT,
        PH_FIN_POLL_CMD, PH_FIN_POLL_DAT
    } t_phase;

    t_phase                     r_phase, n_phase;
    t_command                   r_operation, n_operation;
    logic [ADDRESS_BITS-1:0]    r_flash_address, n_flash_address;
    logic [LEN_W-1:0]           r_bytes_left, n_bytes_left;
    logic [END_W-1:0]           r_range_end, n_range_end;
    logic [IDX_W-1:0]           r_byte_index, n_byte_index;
    logic [TIMEOUT_W-1:0]       r_wait_ms, n_wait_ms;

    logic [8*ADDR_BYTES-1:0]    addr_ext;
    logic [BYTE_W-1:0]          addr_byte;
    logic                       addr_last;
    logic [END_W-1:0]           next_sector;
    logic [LEN_W:0]             page_end;
    logic [LEN_W-1:0]           left_dec;
    logic                       sector_ok;
    logic                       is_erase;

    // len == 0 is in range; otherwise addr + len must not pass the flash end
    function automatic logic in_range(input logic [IN_ADDR_W-1:0] a,
                                      input logic [LEN_W-1:0] len);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(len);
        return (len == '0) || (s <= FLASH_SIZE);
    endfunction

    assign addr_ext    = (8*ADDR_BYTES)'(r_flash_address);
    assign addr_last   = (r_byte_index == IDX_W'(ADDR_BYTES - 1));
    assign next_sector = END_W'(r_flash_address) + END_W'(SECTOR_BYTES);
    assign page_end    = (LEN_W+1)'(i_item.address[PAGE_LOG-1:0]) + (LEN_W+1)'(i_item.length);
    assign left_dec    = (r_bytes_left != '0) ? r_bytes_left - LEN_W'(1) : r_bytes_left;
    assign sector_ok   = (i_item.address[SECTOR_LOG-1:0] == '0) &&
                         in_range(i_item.address, LEN_W'(SECTOR_BYTES));
    assign is_erase    = (r_operation == CMD_SECTOR_ERASE) ||
                         (r_operation == CMD_ERASE_RANGE);

    // address bytes go out most significant first
    always_comb begin
        addr_byte = '0;
        for (int k = 0; k < ADDR_BYTES; k++) begin
            if (r_byte_index == IDX_W'(ADDR_BYTES - 1 - k)) begin
                addr_byte = addr_ext[8*k +: 8];
            end
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_operation     = r_operation;
        n_flash_address = r_flash_address;
        n_bytes_left    = r_bytes_left;
        n_range_end     = r_range_end;
        n_byte_index    = r_byte_index;
        n_wait_ms       = r_wait_ms;
        o_have_res      = 1'b0;
        o_res           = '0;

        if (i_step) begin
            unique case (i_item.command)
                CMD_READ_ID, CMD_READ, CMD_PROGRAM, CMD_SECTOR_ERASE,
                CMD_ERASE_RANGE: begin
                    if (r_phase == PH_IDLE) begin
                        o_have_res      = 1'b1;
                        n_operation     = i_item.command;
                        n_flash_address = i_item.address[ADDRESS_BITS-1:0];
                        n_bytes_left    = i_item.length;
                        n_byte_index    = '0;
                        n_wait_ms       = '0;
                        priority if (i_item.command == CMD_READ_ID) begin
                            n_phase            = PH_ID_CMD;
                            o_res.send_valid   = 1'b1;
                            o_res.send_byte    = OP_RDID;
                            o_res.select_start = 1'b1;
                        end else if (i_item.command == CMD_SECTOR_ERASE) begin
                            if (sector_ok) begin
                                n_phase            = PH_WE_CMD;
                                o_res.send_valid   = 1'b1;
                                o_res.send_byte    = OP_WREN;
                                o_res.select_start = 1'b1;
                                o_res.select_end   = 1'b1;
                            end else begin
                                o_res.done_res = 1'b1;
                                o_res.status   = ST_RANGE;
                            end
                        end else if (i_item.length == '0) begin
                            o_res.done_res = 1'b1;
                            o_res.status   = ST_OK;
                        end else if (!in_range(i_item.address, i_item.length)) begin
                            o_res.done_res = 1'b1;
                            o_res.status   = ST_RANGE;
                        end else if (i_item.command == CMD_READ) begin
                            n_phase            = PH_ADDR;
                            o_res.send_valid   = 1'b1;
                            o_res.send_byte    = OP_READ;
                            o_res.select_start = 1'b1;
                        end else if (i_item.command == CMD_PROGRAM) begin
                            if (page_end > (LEN_W+1)'(PAGE_BYTES)) begin
                                o_res.done_res = 1'b1;
                                o_res.status   = ST_RANGE;
                            end else begin
                                n_phase            = PH_WE_CMD;
                                o_res.send_valid   = 1'b1;
                                o_res.send_byte    = OP_WREN;
                                o_res.select_start = 1'b1;
                                o_res.select_end   = 1'b1;
                            end
                        end else begin
                            // range erase: in range, so the first aligned sector is too
                            n_range_end     = END_W'(SUM_W'(i_item.address) +
                                                     SUM_W'(i_item.length));
                            n_flash_address = {i_item.address[ADDRESS_BITS-1:SECTOR_LOG],
                                               SECTOR_LOG'(0)};
                            n_phase            = PH_WE_CMD;
                            o_res.send_valid   = 1'b1;
                            o_res.send_byte    = OP_WREN;
                            o_res.select_start = 1'b1;
                            o_res.select_end   = 1'b1;
                        end
                    end
                end
                CMD_DATA_BYTE: begin
                    if (r_phase == PH_DATA_WAIT) begin
                        o_have_res       = 1'b1;
                        n_bytes_left     = left_dec;
                        n_phase          = PH_DATA_SENT;
                        o_res.send_valid = 1'b1;
                        o_res.send_byte  = i_item.data_byte;
                        o_res.select_end = (left_dec == '0);
                    end
                end
                CMD_TICK: begin
                    if ((r_phase == PH_WE_POLL_CMD || r_phase == PH_WE_POLL_DAT ||
                         r_phase == PH_FIN_POLL_CMD || r_phase == PH_FIN_POLL_DAT) &&
                        (r_wait_ms != '1)) begin
                        n_wait_ms = r_wait_ms + TIMEOUT_W'(1);
                    end
                end
                CMD_FLASH_BYTE: begin
                    unique case (r_phase)
                        PH_ID_CMD: begin
                            o_have_res       = 1'b1;
                            n_phase          = PH_ID_DATA;
                            n_byte_index     = '0;
                            o_res.send_valid = 1'b1;
                            o_res.send_byte  = DUMMY;
                        end
                        PH_ID_DATA: begin
                            o_have_res        = 1'b1;
                            o_res.reply_valid = 1'b1;
                            o_res.reply_byte  = i_item.flash_byte;
                            if (r_byte_index < IDX_W'(2)) begin
                                n_byte_index     = r_byte_index + IDX_W'(1);
                                o_res.send_valid = 1'b1;
                                o_res.send_byte  = DUMMY;
                                o_res.select_end = (r_byte_index == IDX_W'(1));
                            end else begin
                                n_phase        = PH_IDLE;
                                o_res.done_res = 1'b1;
                                o_res.status   = ST_OK;
                            end
                        end
                        PH_ADDR: begin
                            o_have_res = 1'b1;
                            priority if (r_byte_index < IDX_W'(ADDR_BYTES)) begin
                                o_res.send_valid = 1'b1;
                                o_res.send_byte  = addr_byte;
                                o_res.select_end = addr_last && is_erase;
                                n_byte_index     = r_byte_index + IDX_W'(1);
                            end else if (r_operation == CMD_READ) begin
                                n_phase          = PH_READ_DATA;
                                o_res.send_valid = 1'b1;
                                o_res.send_byte  = DUMMY;
                                o_res.select_end = (r_bytes_left == LEN_W'(1));
                            end else if (r_operation == CMD_PROGRAM) begin
                                n_phase         = PH_DATA_WAIT;
                                o_res.want_data = 1'b1;
                            end else begin
                                n_wait_ms          = '0;
                                n_phase            = PH_FIN_POLL_CMD;
                                o_res.send_valid   = 1'b1;
                                o_res.send_byte    = OP_RDSR;
                                o_res.select_start = 1'b1;
                            end
                        end
                        PH_READ_DATA: begin
                            o_have_res        = 1'b1;
                            o_res.reply_valid = 1'b1;
                            o_res.reply_byte  = i_item.flash_byte;
                            n_bytes_left      = left_dec;
                            if (left_dec == '0) begin
                                n_phase        = PH_IDLE;
                                o_res.done_res = 1'b1;
                                o_res.status   = ST_OK;
                            end else begin
                                o_res.send_valid = 1'b1;
                                o_res.send_byte  = DUMMY;
                                o_res.select_end = (left_dec == LEN_W'(1));
                            end
                        end
                        PH_WE_CMD: begin
                            o_have_res         = 1'b1;
                            n_wait_ms          = '0;
                            n_phase            = PH_WE_POLL_CMD;
                            o_res.send_valid   = 1'b1;
                            o_res.send_byte    = OP_RDSR;
                            o_res.select_start = 1'b1;
                        end
                        PH_WE_POLL_CMD, PH_FIN_POLL_CMD: begin
                            o_have_res       = 1'b1;
                            n_phase          = (r_phase == PH_WE_POLL_CMD) ?
                                               PH_WE_POLL_DAT : PH_FIN_POLL_DAT;
                            o_res.send_valid = 1'b1;
                            o_res.send_byte  = DUMMY;
                            o_res.select_end = 1'b1;
                        end
                        PH_WE_POLL_DAT, PH_FIN_POLL_DAT: begin
                            o_have_res = 1'b1;
                            priority if (i_item.flash_byte[0]) begin
                                // still busy
                                if (r_wait_ms > i_timeout_ms) begin
                                    n_phase        = PH_IDLE;
                                    o_res.done_res = 1'b1;
                                    o_res.status   = ST_TIMEOUT;
                                end else begin
                                    n_phase            = (r_phase == PH_WE_POLL_DAT) ?
                                                         PH_WE_POLL_CMD : PH_FIN_POLL_CMD;
                                    o_res.send_valid   = 1'b1;
                                    o_res.send_byte    = OP_RDSR;
                                    o_res.select_start = 1'b1;
                                end
                            end else if (r_phase == PH_WE_POLL_DAT) begin
                                n_phase            = PH_ADDR;
                                n_byte_index       = '0;
                                o_res.send_valid   = 1'b1;
                                o_res.send_byte    = (r_operation == CMD_PROGRAM) ?
                                                     OP_PROG : OP_SE;
                                o_res.select_start = 1'b1;
                            end else if ((r_operation == CMD_ERASE_RANGE) &&
                                         (next_sector < r_range_end)) begin
                                // next sector is aligned and inside the flash
                                n_flash_address    = next_sector[ADDRESS_BITS-1:0];
                                n_phase            = PH_WE_CMD;
                                o_res.send_valid   = 1'b1;
                                o_res.send_byte    = OP_WREN;
                                o_res.select_start = 1'b1;
                                o_res.select_end   = 1'b1;
                            end else begin
                                n_phase        = PH_IDLE;
                                o_res.done_res = 1'b1;
                                o_res.status   = ST_OK;
                            end
                        end
                        PH_DATA_SENT: begin
                            o_have_res = 1'b1;
                            if (r_bytes_left != '0) begin
                                n_phase         = PH_DATA_WAIT;
                                o_res.want_data = 1'b1;
                            end else begin
                                n_wait_ms          = '0;
                                n_phase            = PH_FIN_POLL_CMD;
                                o_res.send_valid   = 1'b1;
                                o_res.send_byte    = OP_RDSR;
                                o_res.select_start = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_operation     <= CMD_READ_ID;
            r_flash_address <= '0;
            r_bytes_left    <= '0;
            r_range_end     <= '0;
            r_byte_index    <= '0;
            r_wait_ms       <= '0;
        end else begin
            r_phase         <= n_phase;
            r_operation     <= n_operation;
            r_flash_address <= n_flash_address;
            r_bytes_left    <= n_bytes_left;
            r_range_end     <= n_range_end;
            r_byte_index    <= n_byte_index;
            r_wait_ms       <= n_wait_ms;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/spi_nor_flash_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer
// Byte-level SPI NOR flash command sequencer with stream in and out.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one item per request, flash byte, program byte or 1 ms
//    tick. tuser carries the command; tdata the address, length, program
//    byte and returned flash byte.
//  - Master stream: at most one result item per input item: byte to shift
//    out with chip-select framing, reply byte, program-byte request, done
//    with status. Items that cause nothing produce no output.
//  - Config channel: writes timeout_ms (reset 5000). Write only when idle;
//    cfg_ready is always high.
//  - Path: an accepted item sits in the input register; when the output
//    register is free or being emptied, its result moves into the output
//    register, whose valid bit drives tvalid.
//  - Throughput: one item per cycle unless the output stalls. The sequencer
//    state updates in one pass of logic between the input and output registers.
//  - Stall: when the output holds an untaken item, the input register
//    holds too; s_axis_tready drops only while both are full.
//  - Reset (synchronous, active low) empties both registers, returns the
//    sequencer to idle and restores the timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_nor_flash_command_sequencer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // address[31:0], length[56:32], data_byte[64:57], flash_byte[72:65], zero pad
    input  wire logic [snfcs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // command[2:0]
    input  wire logic [snfcs_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    // master stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // send_byte[7:0], select_start[8], select_end[9], reply_byte[17:10],
    // status[19:18], zero pad
    output logic [snfcs_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    // send_valid[0], reply_valid[1], want_data[2], done_res[3]
    output logic [snfcs_pkg::M_TUSER_W-1:0]          m_axis_tuser,
    // config write channel (timeout_ms)
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [snfcs_pkg::TIMEOUT_W-1:0]     i_cfg_data
);
    import snfcs_pkg::*;

    logic                   r_in_valid;
    t_item                  r_in;
    logic                   r_out_valid;
    t_result                r_out;
    logic [TIMEOUT_W-1:0]   r_timeout_ms;

    logic                   advance;
    logic                   have_res;
    t_result                core_res;
    t_item                  in_item;

    assign in_item.command    = t_command'(s_axis_tuser);
    assign in_item.address    = s_axis_tdata[31:0];
    assign in_item.length     = s_axis_tdata[56:32];
    assign in_item.data_byte  = s_axis_tdata[64:57];
    assign in_item.flash_byte = s_axis_tdata[72:65];

    // input item moves on when the output register is free or being emptied
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    snfcs_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_item       (r_in),
        .i_timeout_ms (r_timeout_ms),
        .o_have_res   (have_res),
        .o_res        (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_timeout_ms <= TIMEOUT_RESET;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
                r_in       <= in_item;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance && have_res) begin
                r_out_valid <= 1'b1;
                r_out       <= core_res;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout_ms <= i_cfg_data;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out.status, r_out.reply_byte, r_out.select_end,
                            r_out.select_start, r_out.send_byte};
    assign m_axis_tuser  = {r_out.done_res, r_out.want_data, r_out.reply_valid,
                            r_out.send_valid};

    // reset leaves both registers empty
    assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid && !r_in_valid)
        else $error("registers not empty after reset");

    // every result item carries something
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.send_valid || r_out.reply_valid ||
                           r_out.want_data || r_out.done_res))
        else $error("empty result item");

    // a status other than ok only comes with done
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && have_res && core_res.status != ST_OK) |=> r_out.done_res)
        else $error("status without done");

    // a program-byte request never comes with a byte to send or with done
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.want_data |-> !r_out.send_valid && !r_out.done_res)
        else $error("want_data mixed with send or done");

endmodule

`default_nettype wire

// ===== sim/tb_spi_nor_flash_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_spi_nor_flash_command_sequencer
// Self-checking bench for the SPI NOR flash command sequencer. The bench acts
// as both the requester and the flash: it drives requests, returned flash
// bytes, program bytes and 1 ms ticks. A cycle-free model of the sequencer
// predicts every result item, and each result is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_spi_nor_flash_command_sequencer;

    import snfcs_pkg::*;

    localparam int          QUIET_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int          DRAIN_CYCLES = 6;      // extra wait once every awaited result is in
    localparam int unsigned FLASH_BYTES  = 1 << ADDRESS_BITS;
    localparam logic [BYTE_W-1:0] BUSY_MASK = 8'h01;

    // Sequencer phases as the model tracks them
    typedef enum logic [3:0] {
        SQ_IDLE, SQ_ID_CMD, SQ_ID_DATA, SQ_ADDR, SQ_READ_DATA, SQ_WE_CMD,
        SQ_WE_POLL_CMD, SQ_WE_POLL_DAT, SQ_DATA_WAIT, SQ_DATA_SENT,
        SQ_FIN_POLL_CMD, SQ_FIN_POLL_DAT
    } t_seq_phase;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [TIMEOUT_W-1:0]   i_cfg_data    = '0;

    spi_nor_flash_command_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Traffic shaping knobs
    int unsigned idle_pct  = 0;    // sender gaps
    int unsigned stall_pct = 0;    // receiver back-pressure
    int unsigned busy_pct  = 50;   // status reads that report busy
    int unsigned tick_pct  = 30;   // ticks sent during a busy wait

    int          mismatches   = 0;
    int          quiet_cycles = 0;
    t_result     awaited_outputs[$];

    // ------------------------------------------------------------------------
    // Sequencer model state
    // ------------------------------------------------------------------------
    logic [TIMEOUT_W-1:0]   sq_timeout = TIMEOUT_RESET;
    t_seq_phase             sq_phase   = SQ_IDLE;
    t_command               sq_op      = CMD_READ_ID;
    logic [32:0]            sq_addr    = '0;   // full request address, plus carry
    logic [LEN_W-1:0]       sq_left    = '0;
    logic [32:0]            sq_end     = '0;
    logic [IDX_W-1:0]       sq_idx     = '0;
    logic [TIMEOUT_W-1:0]   sq_wait    = '0;

    t_result                nxt;
    bit                     nxt_any;

    function automatic void put_send(logic [BYTE_W-1:0] b, logic ss, logic se);
        nxt_any           = 1'b1;
        nxt.send_valid    = 1'b1;
        nxt.send_byte     = b;
        nxt.select_start  = ss;
        nxt.select_end    = se;
    endfunction

    function automatic void put_reply(logic [BYTE_W-1:0] b);
        nxt_any         = 1'b1;
        nxt.reply_valid = 1'b1;
        nxt.reply_byte  = b;
    endfunction

    function automatic void put_done(t_status st);
        nxt_any      = 1'b1;
        nxt.done_res = 1'b1;
        nxt.status   = st;
        sq_phase     = SQ_IDLE;
    endfunction

    function automatic void ask_data();
        nxt_any       = 1'b1;
        nxt.want_data = 1'b1;
        sq_phase      = SQ_DATA_WAIT;
    endfunction

    function automatic void start_poll(t_seq_phase ph);
        sq_phase = ph;
        put_send(OP_RDSR, 1'b1, 1'b0);
    endfunction

    function automatic void start_wren();
        sq_phase = SQ_WE_CMD;
        put_send(OP_WREN, 1'b1, 1'b1);
    endfunction

    function automatic bit fits_flash(logic [32:0] a, logic [32:0] len);
        if (len == 0)
            return 1'b1;
        if (a >= FLASH_BYTES)
            return 1'b0;
        return len <= FLASH_BYTES - a;
    endfunction

    function automatic bit in_poll();
        return sq_phase == SQ_WE_POLL_CMD || sq_phase == SQ_WE_POLL_DAT ||
               sq_phase == SQ_FIN_POLL_CMD || sq_phase == SQ_FIN_POLL_DAT;
    endfunction

    function automatic void open_sector();
        if ((sq_addr % SECTOR_BYTES) != 0 || !fits_flash(sq_addr, SECTOR_BYTES))
            put_done(ST_RANGE);
        else
            start_wren();
    endfunction

    // Status register read came back; busy keeps polling until the timeout
    function automatic void poll_answer(logic [BYTE_W-1:0] fb, bit final_stage);
        if ((fb & BUSY_MASK) != 0) begin
            if (sq_wait > sq_timeout)
                put_done(ST_TIMEOUT);
            else
                start_poll(final_stage ? SQ_FIN_POLL_CMD : SQ_WE_POLL_CMD);
        end else if (!final_stage) begin
            sq_phase = SQ_ADDR;
            sq_idx   = '0;
            put_send(sq_op == CMD_PROGRAM ? OP_PROG : OP_SE, 1'b1, 1'b0);
        end else begin
            if (sq_op == CMD_ERASE_RANGE) begin
                sq_addr = sq_addr + SECTOR_BYTES;
                if (sq_addr < sq_end) begin
                    open_sector();
                    return;
                end
            end
            put_done(ST_OK);
        end
    endfunction

    function automatic void take_request(t_command cmd, logic [IN_ADDR_W-1:0] a,
                                         logic [LEN_W-1:0] len);
        sq_op   = cmd;
        sq_addr = {1'b0, a};
        sq_left = len;
        sq_idx  = '0;
        sq_wait = '0;
        case (cmd)
            CMD_READ_ID: begin
                sq_phase = SQ_ID_CMD;
                put_send(OP_RDID, 1'b1, 1'b0);
            end
            CMD_READ: begin
                if (len == 0)
                    put_done(ST_OK);
                else if (!fits_flash(sq_addr, len))
                    put_done(ST_RANGE);
                else begin
                    sq_phase = SQ_ADDR;
                    put_send(OP_READ, 1'b1, 1'b0);
                end
            end
            CMD_PROGRAM: begin
                if (len == 0)
                    put_done(ST_OK);
                else if (len > PAGE_BYTES || (a % PAGE_BYTES) + len > PAGE_BYTES ||
                         !fits_flash(sq_addr, len))
                    put_done(ST_RANGE);
                else
                    start_wren();
            end
            CMD_SECTOR_ERASE: open_sector();
            default: begin
                if (len == 0)
                    put_done(ST_OK);
                else if (!fits_flash(sq_addr, len))
                    put_done(ST_RANGE);
                else begin
                    sq_end  = sq_addr + len;
                    sq_addr = sq_addr - (sq_addr % SECTOR_BYTES);
                    open_sector();
                end
            end
        endcase
    endfunction

    function automatic void flash_answer(logic [BYTE_W-1:0] fb);
        logic [32:0] shifted;
        bit          erase;
        case (sq_phase)
            SQ_ID_CMD: begin
                sq_phase = SQ_ID_DATA;
                sq_idx   = '0;
                put_send(DUMMY, 1'b0, 1'b0);
            end
            SQ_ID_DATA: begin
                put_reply(fb);
                if (sq_idx < 2) begin
                    sq_idx++;
                    put_send(DUMMY, 1'b0, sq_idx == 2);
                end else
                    put_done(ST_OK);
            end
            SQ_ADDR: begin
                if (sq_idx < ADDR_BYTES) begin
                    // address goes out most significant byte first
                    shifted = sq_addr >> (8 * (ADDR_BYTES - 1 - sq_idx));
                    erase   = sq_op == CMD_SECTOR_ERASE || sq_op == CMD_ERASE_RANGE;
                    put_send(shifted[BYTE_W-1:0], 1'b0, (sq_idx + 1 == ADDR_BYTES) && erase);
                    sq_idx++;
                end else if (sq_op == CMD_READ) begin
                    sq_phase = SQ_READ_DATA;
                    put_send(DUMMY, 1'b0, sq_left == 1);
                end else if (sq_op == CMD_PROGRAM)
                    ask_data();
                else begin
                    sq_wait = '0;
                    start_poll(SQ_FIN_POLL_CMD);
                end
            end
            SQ_READ_DATA: begin
                put_reply(fb);
                if (sq_left > 0)
                    sq_left--;
                if (sq_left == 0)
                    put_done(ST_OK);
                else
                    put_send(DUMMY, 1'b0, sq_left == 1);
            end
            SQ_WE_CMD: begin
                sq_wait = '0;
                start_poll(SQ_WE_POLL_CMD);
            end
            SQ_WE_POLL_CMD: begin
                sq_phase = SQ_WE_POLL_DAT;
                put_send(DUMMY, 1'b0, 1'b1);
            end
            SQ_WE_POLL_DAT: poll_answer(fb, 1'b0);
            SQ_DATA_SENT: begin
                if (sq_left > 0)
                    ask_data();
                else begin
                    sq_wait = '0;
                    start_poll(SQ_FIN_POLL_CMD);
                end
            end
            SQ_FIN_POLL_CMD: begin
                sq_phase = SQ_FIN_POLL_DAT;
                put_send(DUMMY, 1'b0, 1'b1);
            end
            SQ_FIN_POLL_DAT: poll_answer(fb, 1'b1);
            default: ;
        endcase
    endfunction

    // Advance the model by one accepted item; returns 1 when it yields a result
    function automatic bit sequencer_step(t_item it, output t_result r);
        nxt     = '0;
        nxt_any = 1'b0;
        case (it.command)
            CMD_DATA_BYTE: begin
                if (sq_phase == SQ_DATA_WAIT) begin
                    if (sq_left > 0)
                        sq_left--;
                    sq_phase = SQ_DATA_SENT;
                    put_send(it.data_byte, 1'b0, sq_left == 0);
                end
            end
            CMD_FLASH_BYTE: flash_answer(it.flash_byte);
            CMD_TICK: begin
                if (in_poll() && sq_wait != '1)
                    sq_wait++;
            end
            default: begin
                if (sq_phase == SQ_IDLE)
                    take_request(it.command, it.address, it.length);
            end
        endcase
        r = nxt;
        return nxt_any;
    endfunction

    // ------------------------------------------------------------------------
    // Item generators
    // ------------------------------------------------------------------------
    function automatic t_item any_item();
        t_item it;
        it.command    = t_command'($urandom_range(CMD_READ_ID, CMD_TICK));
        it.address    = $urandom;
        it.length     = LEN_W'($urandom);
        it.data_byte  = BYTE_W'($urandom);
        it.flash_byte = BYTE_W'($urandom);
        return it;
    endfunction

    // Whatever a well-behaved requester and flash would send next
    function automatic t_item follow_item();
        t_item it;
        it = any_item();
        case (sq_phase)
            SQ_DATA_WAIT: it.command = CMD_DATA_BYTE;
            SQ_WE_POLL_CMD, SQ_WE_POLL_DAT, SQ_FIN_POLL_CMD, SQ_FIN_POLL_DAT: begin
                if ($urandom_range(0, 99) < tick_pct)
                    it.command = CMD_TICK;
                else begin
                    it.command = CMD_FLASH_BYTE;
                    if (sq_phase == SQ_WE_POLL_DAT || sq_phase == SQ_FIN_POLL_DAT)
                        it.flash_byte[0] = $urandom_range(0, 99) < busy_pct;
                end
            end
            default: it.command = CMD_FLASH_BYTE;
        endcase
        return it;
    endfunction

    // A range that always fails: past the flash, over its top, or too long
    function automatic void spoil_range(ref t_item it);
        int unsigned n;
        case ($urandom_range(0, 2))
            0: begin
                it.address = $urandom_range(FLASH_BYTES, 32'hFFFF_FFFF);
                it.length  = LEN_W'($urandom_range(1, 8));
            end
            1: begin
                n          = $urandom_range(2, 64);
                it.length  = LEN_W'(n);
                it.address = FLASH_BYTES - n + $urandom_range(1, n - 1);
            end
            default: begin
                it.length          = LEN_W'($urandom_range(1, FLASH_BYTES - 1));
                it.length[LEN_W-1] = 1'b1;
            end
        endcase
    endfunction

    function automatic t_item request_item();
        t_item       it;
        int unsigned roll, n, off;
        it         = any_item();
        it.command = t_command'($urandom_range(CMD_READ_ID, CMD_ERASE_RANGE));
        roll       = $urandom_range(0, 99);
        case (it.command)
            CMD_READ, CMD_ERASE_RANGE: begin
                if (roll < 60) begin
                    n = (it.command == CMD_READ) ? $urandom_range(1, 6)
                                                 : $urandom_range(1, 3 * SECTOR_BYTES);
                    it.length  = LEN_W'(n);
                    it.address = $urandom_range(0, FLASH_BYTES - n);
                end else if (roll < 70)
                    it.length = '0;
                else
                    spoil_range(it);
            end
            CMD_PROGRAM: begin
                if (roll < 65) begin
                    n   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PAGE_BYTES)
                                                      : $urandom_range(1, 8);
                    off = $urandom_range(0, PAGE_BYTES - n);
                    it.length  = LEN_W'(n);
                    it.address = $urandom_range(0, FLASH_BYTES / PAGE_BYTES - 1) * PAGE_BYTES
                                 + off;
                end else if (roll < 75)
                    it.length = '0;
                else if (roll < 85) begin
                    // crosses into the next page
                    n   = $urandom_range(2, PAGE_BYTES);
                    off = $urandom_range(PAGE_BYTES - n + 1, PAGE_BYTES - 1);
                    it.length  = LEN_W'(n);
                    it.address = $urandom_range(0, FLASH_BYTES / PAGE_BYTES - 1) * PAGE_BYTES
                                 + off;
                end else if (roll < 92)
                    it.length = LEN_W'($urandom_range(PAGE_BYTES + 1, 32'h1FF_FFFF));
                else begin
                    it.address = $urandom_range(FLASH_BYTES, 32'hFFFF_FFFF);
                    it.length  = LEN_W'($urandom_range(1, 8));
                end
            end
            CMD_SECTOR_ERASE: begin
                it.address = $urandom_range(0, FLASH_BYTES / SECTOR_BYTES - 1) * SECTOR_BYTES;
                if (roll >= 85)
                    it.address = $urandom_range(FLASH_BYTES / SECTOR_BYTES, 32'hF_FFFF)
                                 * SECTOR_BYTES;
                else if (roll >= 70)
                    it.address = it.address + $urandom_range(1, SECTOR_BYTES - 1);
            end
            default: ;
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic void log_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    // Called at a rising edge; returns at the edge that took the item
    task automatic send_item(input t_item it);
        t_result r;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({it.flash_byte, it.data_byte, it.length, it.address});
        s_axis_tuser  <= it.command;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (sequencer_step(it, r))
            awaited_outputs.push_back(r);
    endtask

    task automatic send_request(input t_command cmd, input logic [IN_ADDR_W-1:0] a,
                                input logic [LEN_W-1:0] len);
        t_item it;
        it         = any_item();
        it.command = cmd;
        it.address = a;
        it.length  = len;
        send_item(it);
    endtask

    task automatic send_cmd(input t_command cmd);
        t_item it;
        it         = any_item();
        it.command = cmd;
        send_item(it);
    endtask

    task automatic finish_flow();
        while (sq_phase != SQ_IDLE)
            send_item(follow_item());
    endtask

    // Let every result come out and the pipeline go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sq_timeout = v;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_stray_items();
        send_cmd(CMD_DATA_BYTE);
        send_cmd(CMD_FLASH_BYTE);
        send_cmd(CMD_TICK);
    endtask

    task automatic test_id_and_read();
        send_request(CMD_READ_ID, '0, '0);
        finish_flow();
        send_request(CMD_READ, '0, 1);
        finish_flow();
        send_request(CMD_READ, FLASH_BYTES - 2, 2);      // last two bytes of flash
        finish_flow();
        send_request(CMD_READ, '1, '0);                  // zero length wins over range
        send_request(CMD_READ, FLASH_BYTES - 1, 2);      // runs off the top
        send_request(CMD_READ, '1, 1);
        send_request(CMD_READ, '0, '1);
    endtask

    task automatic test_program();
        send_request(CMD_PROGRAM, 32'h0000_00F0, 16);   // ends exactly on page edge
        finish_flow();
        send_request(CMD_PROGRAM, FLASH_BYTES - PAGE_BYTES, PAGE_BYTES);
        finish_flow();
        send_request(CMD_PROGRAM, 32'h0001_2300, '0);
        send_request(CMD_PROGRAM, 32'h0000_00F8, 16);   // page crossing
        send_request(CMD_PROGRAM, '0, PAGE_BYTES + 1);
        send_request(CMD_PROGRAM, 32'hFFFF_FF00, 1);
    endtask

    task automatic test_sector_erase();
        send_request(CMD_SECTOR_ERASE, FLASH_BYTES - SECTOR_BYTES, '0);
        finish_flow();
        send_request(CMD_SECTOR_ERASE, 32'h0000_1001, '0);
        send_request(CMD_SECTOR_ERASE, FLASH_BYTES, '0);
    endtask

    task automatic test_range_erase();
        send_request(CMD_ERASE_RANGE, SECTOR_BYTES - 1, 2);   // touches two sectors
        finish_flow();
        send_request(CMD_ERASE_RANGE, '0, '0);
        send_request(CMD_ERASE_RANGE, FLASH_BYTES - 1, 2);
    endtask

    // New requests while one is running must be dropped
    task automatic test_request_while_busy();
        send_request(CMD_READ, 32'h0000_0100, 3);
        send_item(follow_item());
        send_request(CMD_READ_ID, '0, '0);
        send_request(CMD_PROGRAM, '0, 1);
        finish_flow();
    endtask

    task automatic test_busy_timeout();
        settle();
        write_timeout(1);
        busy_pct = 100;
        tick_pct = 50;
        send_request(CMD_SECTOR_ERASE, 32'h0000_2000, '0);
        finish_flow();
        send_request(CMD_PROGRAM, 32'h0000_0040, 2);
        finish_flow();
        busy_pct = 50;
        tick_pct = 30;
    endtask

    // With the largest timeout a long run of ticks does not end the wait,
    // so a busy status keeps polling
    task automatic test_long_busy_wait();
        t_item it;
        settle();
        write_timeout('1);
        busy_pct = 0;
        tick_pct = 0;
        send_request(CMD_SECTOR_ERASE, '0, '0);
        send_item(follow_item());                     // write enable answered
        repeat (100) send_cmd(CMD_TICK);
        send_item(follow_item());                     // status opcode answered
        it = follow_item();
        it.flash_byte[0] = 1'b1;
        send_item(it);
        finish_flow();
        busy_pct = 50;
        tick_pct = 30;
    endtask

    task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                       input bit set_timeout,
                                       input logic [TIMEOUT_W-1:0] tmo, input int n);
        int    taken;
        t_item it;
        settle();
        if (set_timeout)
            write_timeout(tmo);
        idle_pct  = gap;
        stall_pct = stall;
        taken     = 0;
        while (taken < n || sq_phase != SQ_IDLE) begin
            if (taken < n && $urandom_range(0, 99) < 8) begin
                // noise: stray bytes and ticks when idle, anything when busy
                it = any_item();
                if (sq_phase == SQ_IDLE)
                    it.command = t_command'($urandom_range(CMD_DATA_BYTE, CMD_TICK));
            end else begin
                it = (sq_phase == SQ_IDLE) ? request_item() : follow_item();
                taken++;
            end
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk)
        m_axis_tready <= $urandom_range(0, 99) >= stall_pct;

    function automatic string show(t_result r);
        return $sformatf("snd=%0d/%02h ss=%0d se=%0d rep=%0d/%02h want=%0d done=%0d st=%0d",
                         r.send_valid, r.send_byte, r.select_start, r.select_end,
                         r.reply_valid, r.reply_byte, r.want_data, r.done_res, r.status);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.send_valid   = m_axis_tuser[0];
            got.reply_valid  = m_axis_tuser[1];
            got.want_data    = m_axis_tuser[2];
            got.done_res     = m_axis_tuser[3];
            got.send_byte    = m_axis_tdata[7:0];
            got.select_start = m_axis_tdata[8];
            got.select_end   = m_axis_tdata[9];
            got.reply_byte   = m_axis_tdata[17:10];
            got.status       = t_status'(m_axis_tdata[19:18]);
            if (awaited_outputs.size() == 0)
                log_error($sformatf("%0t: unexpected result %s", $time, show(got)));
            else begin
                want = awaited_outputs.pop_front();
                if (got.send_valid !== want.send_valid || got.send_byte !== want.send_byte ||
                    got.select_start !== want.select_start ||
                    got.select_end !== want.select_end ||
                    got.reply_valid !== want.reply_valid ||
                    got.reply_byte !== want.reply_byte || got.want_data !== want.want_data ||
                    got.done_res !== want.done_res || got.status !== want.status)
                    log_error($sformatf("%0t: mismatch\n  exp %s\n  got %s", $time,
                                        show(want), show(got)));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_spi_nor_flash_command_sequencer: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stray_items();
        test_id_and_read();
        test_program();
        test_sector_erase();
        test_range_erase();
        test_request_while_busy();
        test_busy_timeout();
        test_long_busy_wait();

        // the first random run writes the reset timeout value back
        test_random_traffic(0, 0, 1'b1, TIMEOUT_RESET, 100);
        test_random_traffic(61, 0, 1'b1, '0, 100);
        test_random_traffic(0, 61, 1'b1, '1, 100);
        test_random_traffic(30, 30, 1'b1, TIMEOUT_W'($urandom_range(1, 8)), 100);

        settle();
        if (awaited_outputs.size() != 0)
            log_error($sformatf("%0d results never arrived", awaited_outputs.size()));
        if (mismatches == 0)
            $display("tb_spi_nor_flash_command_sequencer: PASS");
        else
            $display("tb_spi_nor_flash_command_sequencer: FAIL");
        $finish;
    end

endmodule
